// File: hw/rtl/gyi_pkg.sv
// gyi_pkg: shared types and constants of the gyro yaw integrator
// holds the config struct and the controller/datapath command and status words
// no dependencies
package gyi_pkg;

    // biquad taps, one multiply each
    localparam int NumTaps = 5;
    localparam int TapW    = 3;

    // divide by 10^6: quotient bits, bits per cycle
    localparam int QuoW     = 27;
    localparam int DivBits  = 3;
    localparam int DivSteps = QuoW / DivBits;
    localparam int DivCntW  = 4;

    localparam logic signed [31:0] ALPHA_Q24      = 32'sd33554;
    localparam logic signed [32:0] BIAS_LIMIT     = 33'sd131072;
    localparam logic signed [32:0] BIAS_LIMIT_NEG = -33'sd131072;
    localparam logic [15:0]        DT_MIN_US      = 16'd1000;
    localparam logic [15:0]        DT_MAX_US      = 16'd50000;
    localparam logic [15:0]        DT_DEFAULT_US  = 16'd10000;
    localparam logic [19:0]        US_PER_S       = 20'd1000000;
    localparam logic [47:0]        HALF_US_PER_S  = 48'd500000;

    typedef enum logic [1:0] {
        MODE_RAW  = 2'd0,
        MODE_DZ   = 2'd1,
        MODE_LPF  = 2'd2,
        MODE_BIAS = 2'd3
    } mode_t;

    typedef struct packed {
        mode_t       mode;
        logic        learn_en;
        logic [15:0] deadzone;
        logic [31:0] b0;
        logic [31:0] b1;
        logic [31:0] b2;
        logic [31:0] a1;
        logic [31:0] a2;
    } cfg_t;

    typedef enum logic [2:0] {
        MUL_BIAS,
        MUL_B0,
        MUL_B1,
        MUL_B2,
        MUL_A1,
        MUL_A2,
        MUL_DT
    } mul_sel_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_CLR,
        ACC_ADD,
        ACC_SUB
    } acc_op_t;

    typedef struct packed {
        logic     capture;
        logic     load_yaw;
        mul_sel_t mul_sel;
        logic     bias_upd;
        logic     set_used;
        acc_op_t  acc_op;
        logic     filt_upd;
        logic     div_init;
        logic     div_step;
        logic     yaw_upd;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        logic  action;
        mode_t mode;
        logic  learn_en;
        logic  err_ok;
    } sts_t;

endpackage

// File: hw/rtl/gyi_regs.sv
// gyi_regs: apb register file of the gyro yaw integrator
// mode write pulses a history clear toward the datapath
// depends on gyi_pkg
module gyi_regs (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output gyi_pkg::cfg_t       cfg,
    output logic                clr_hist
);

    typedef enum logic [2:0] {
        REG_MODE,
        REG_LEARN,
        REG_DZ,
        REG_B0,
        REG_B1,
        REG_B2,
        REG_A1,
        REG_A2
    } reg_idx_t;

    localparam logic [15:0] RstDeadzone = 16'd3277;
    localparam logic [31:0] RstB0       = 32'd203409651;
    localparam logic [31:0] RstB1       = 32'd406819302;
    localparam logic [31:0] RstB2       = 32'd203409651;
    localparam logic [31:0] RstA1       = 32'hEA4F_A051;   // -363880367
    localparam logic [31:0] RstA2       = 32'd103798622;

    gyi_pkg::cfg_t cfg_reg;
    reg_idx_t      idx;
    logic          wr_en;

    assign idx      = reg_idx_t'(paddr[4:2]);
    assign wr_en    = psel & penable & pwrite;
    assign pready   = 1'b1;
    assign cfg      = cfg_reg;
    assign clr_hist = wr_en && (idx == REG_MODE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mode     <= gyi_pkg::MODE_DZ;
            cfg_reg.learn_en <= 1'b0;
            cfg_reg.deadzone <= RstDeadzone;
            cfg_reg.b0       <= RstB0;
            cfg_reg.b1       <= RstB1;
            cfg_reg.b2       <= RstB2;
            cfg_reg.a1       <= RstA1;
            cfg_reg.a2       <= RstA2;
        end else if (wr_en) begin
            unique case (idx)
                REG_MODE:  cfg_reg.mode     <= gyi_pkg::mode_t'(pwdata[1:0]);
                REG_LEARN: cfg_reg.learn_en <= pwdata[0];
                REG_DZ:    cfg_reg.deadzone <= pwdata[15:0];
                REG_B0:    cfg_reg.b0       <= pwdata;
                REG_B1:    cfg_reg.b1       <= pwdata;
                REG_B2:    cfg_reg.b2       <= pwdata;
                REG_A1:    cfg_reg.a1       <= pwdata;
                REG_A2:    cfg_reg.a2       <= pwdata;
                default:   cfg_reg.mode     <= cfg_reg.mode;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_MODE:  prdata = {30'd0, cfg_reg.mode};
            REG_LEARN: prdata = {31'd0, cfg_reg.learn_en};
            REG_DZ:    prdata = {16'd0, cfg_reg.deadzone};
            REG_B0:    prdata = cfg_reg.b0;
            REG_B1:    prdata = cfg_reg.b1;
            REG_B2:    prdata = cfg_reg.b2;
            REG_A1:    prdata = cfg_reg.a1;
            REG_A2:    prdata = cfg_reg.a2;
            default:   prdata = 32'd0;
        endcase
    end

endmodule

// File: hw/rtl/gyi_dp.sv
// gyi_dp: datapath of the gyro yaw integrator
// shared 32x32 multiplier, biquad accumulator, radix-8 divide by 10^6, yaw state
// depends on gyi_pkg
module gyi_dp (
    input  logic            aclk,
    input  logic            aresetn,
    input  gyi_pkg::cmd_t   cmd,
    input  gyi_pkg::cfg_t   cfg,
    input  logic            clr_hist,
    input  logic            s_tuser,
    input  logic [95:0]     s_tdata,
    output gyi_pkg::sts_t   sts,
    output logic [159:0]    m_tdata
);

    // captured word
    logic               act_reg;
    logic signed [31:0] rate_reg;
    logic [15:0]        us_reg;
    logic [47:0]        angle_reg;

    // architectural state
    logic signed [47:0] yaw_reg;
    logic signed [31:0] bias_reg;
    logic signed [31:0] x1_reg, x2_reg, y1_reg, y2_reg;

    // working registers
    logic signed [31:0] used_reg;
    logic signed [31:0] filt_reg;
    logic signed [63:0] prod_reg;
    logic signed [66:0] acc_reg;
    logic [19:0]        rem_reg;
    logic [26:0]        num_reg;
    logic [26:0]        quo_reg;
    logic               neg_reg;
    logic [159:0]       out_reg;

    logic [15:0]        us_in;
    logic [15:0]        us_chk;
    logic signed [32:0] err;
    logic               err_ok;
    logic signed [63:0] inc;
    logic signed [33:0] bias_sum;
    logic [31:0]        bias_sat;
    logic signed [32:0] diff;
    logic [31:0]        diff_sat;
    logic [31:0]        pre;
    logic [32:0]        mag;
    logic [31:0]        used_val;
    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] mul_p;
    logic signed [66:0] prod_ext;
    logic signed [66:0] rnd;
    logic [31:0]        y_sat;
    logic [47:0]        dt_abs;
    logic [47:0]        dt_num;
    logic [19:0]        rem_nx;
    logic [26:0]        num_nx;
    logic [26:0]        quo_nx;
    logic [48:0]        delta;
    logic [48:0]        yaw_sum;
    logic [47:0]        yaw_sat;

    // interval range check
    assign us_in  = s_tdata[47:32];
    assign us_chk = (us_in < gyi_pkg::DT_MIN_US || us_in > gyi_pkg::DT_MAX_US)
                    ? gyi_pkg::DT_DEFAULT_US : us_in;

    // bias learning, error taken against the bias before update
    assign err    = {rate_reg[31], rate_reg} - {bias_reg[31], bias_reg};
    assign err_ok = (err >= gyi_pkg::BIAS_LIMIT_NEG) && (err <= gyi_pkg::BIAS_LIMIT);
    assign inc    = (prod_reg + 64'sd8388608) >>> 24;
    assign bias_sum = {bias_reg[31], bias_reg[31], bias_reg} + inc[33:0];
    assign bias_sat = (bias_sum[33:31] == 3'b000 || bias_sum[33:31] == 3'b111)
                      ? bias_sum[31:0]
                      : (bias_sum[33] ? 32'h8000_0000 : 32'h7FFF_FFFF);

    // bias subtraction and deadzone
    assign diff     = {rate_reg[31], rate_reg} - {bias_reg[31], bias_reg};
    assign diff_sat = (diff[32] == diff[31]) ? diff[31:0]
                      : (diff[32] ? 32'h8000_0000 : 32'h7FFF_FFFF);
    assign pre      = (cfg.mode == gyi_pkg::MODE_BIAS) ? diff_sat : rate_reg;
    assign mag      = pre[31] ? (33'd0 - {1'b1, pre}) : {1'b0, pre};
    assign used_val = (cfg.mode != gyi_pkg::MODE_RAW && mag < {17'd0, cfg.deadzone})
                      ? 32'd0 : pre;

    // shared multiplier operand select
    always_comb begin
        case (cmd.mul_sel)
            gyi_pkg::MUL_BIAS: begin
                mul_a = err[31:0];
                mul_b = gyi_pkg::ALPHA_Q24;
            end
            gyi_pkg::MUL_B0: begin
                mul_a = cfg.b0;
                mul_b = used_reg;
            end
            gyi_pkg::MUL_B1: begin
                mul_a = cfg.b1;
                mul_b = x1_reg;
            end
            gyi_pkg::MUL_B2: begin
                mul_a = cfg.b2;
                mul_b = x2_reg;
            end
            gyi_pkg::MUL_A1: begin
                mul_a = cfg.a1;
                mul_b = y1_reg;
            end
            gyi_pkg::MUL_A2: begin
                mul_a = cfg.a2;
                mul_b = y2_reg;
            end
            default: begin
                mul_a = filt_reg;
                mul_b = {16'd0, us_reg};
            end
        endcase
    end

    assign mul_p    = mul_a * mul_b;
    assign prod_ext = {{3{prod_reg[63]}}, prod_reg};

    // biquad output, round half up by 2^30 then saturate
    assign rnd   = (acc_reg + 67'sd536870912) >>> 30;
    assign y_sat = (&rnd[66:31] || ~|rnd[66:31]) ? rnd[31:0]
                   : (rnd[66] ? 32'h8000_0000 : 32'h7FFF_FFFF);

    // magnitude of rate times interval plus half the divisor
    assign dt_abs = prod_reg[47] ? (48'd0 - prod_reg[47:0]) : prod_reg[47:0];
    assign dt_num = dt_abs + gyi_pkg::HALF_US_PER_S;

    // three restoring divide steps per cycle
    always_comb begin
        logic [20:0] t;
        rem_nx = rem_reg;
        num_nx = num_reg;
        quo_nx = quo_reg;
        for (int k = 0; k < gyi_pkg::DivBits; k++) begin
            t = {rem_nx, num_nx[26]};
            num_nx = {num_nx[25:0], 1'b0};
            if (t >= {1'b0, gyi_pkg::US_PER_S}) begin
                t = t - {1'b0, gyi_pkg::US_PER_S};
                quo_nx = {quo_nx[25:0], 1'b1};
            end else begin
                quo_nx = {quo_nx[25:0], 1'b0};
            end
            rem_nx = t[19:0];
        end
    end

    // signed delta and saturating yaw sum
    assign delta   = neg_reg ? (49'd0 - {22'd0, quo_reg}) : {22'd0, quo_reg};
    assign yaw_sum = {yaw_reg[47], yaw_reg} + delta;
    assign yaw_sat = (yaw_sum[48] == yaw_sum[47]) ? yaw_sum[47:0]
                     : (yaw_sum[48] ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF);

    // state with reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            yaw_reg  <= '0;
            bias_reg <= '0;
            x1_reg   <= '0;
            x2_reg   <= '0;
            y1_reg   <= '0;
            y2_reg   <= '0;
        end else begin
            if (clr_hist) begin
                bias_reg <= '0;
                x1_reg   <= '0;
                x2_reg   <= '0;
                y1_reg   <= '0;
                y2_reg   <= '0;
            end else if (cmd.load_yaw) begin
                x1_reg <= '0;
                x2_reg <= '0;
                y1_reg <= '0;
                y2_reg <= '0;
            end else if (cmd.filt_upd) begin
                x2_reg <= x1_reg;
                x1_reg <= used_reg;
                y2_reg <= y1_reg;
                y1_reg <= y_sat;
            end
            if (cmd.bias_upd) begin
                bias_reg <= bias_sat;
            end
            if (cmd.load_yaw) begin
                yaw_reg <= angle_reg;
            end else if (cmd.yaw_upd) begin
                yaw_reg <= yaw_sat;
            end
        end
    end

    // working registers, no reset
    always_ff @(posedge aclk) begin
        prod_reg <= mul_p;
        if (cmd.capture) begin
            act_reg   <= s_tuser;
            rate_reg  <= s_tdata[31:0];
            us_reg    <= us_chk;
            angle_reg <= s_tdata[95:48];
        end
        if (cmd.load_yaw) begin
            used_reg <= '0;
            filt_reg <= '0;
        end else if (cmd.set_used) begin
            used_reg <= used_val;
            filt_reg <= used_val;
        end else if (cmd.filt_upd) begin
            filt_reg <= y_sat;
        end
        case (cmd.acc_op)
            gyi_pkg::ACC_CLR: acc_reg <= '0;
            gyi_pkg::ACC_ADD: acc_reg <= acc_reg + prod_ext;
            gyi_pkg::ACC_SUB: acc_reg <= acc_reg - prod_ext;
            default:          acc_reg <= acc_reg;
        endcase
        if (cmd.div_init) begin
            neg_reg <= prod_reg[47];
            rem_reg <= dt_num[46:27];
            num_reg <= dt_num[26:0];
            quo_reg <= '0;
        end else if (cmd.div_step) begin
            rem_reg <= rem_nx;
            num_reg <= num_nx;
            quo_reg <= quo_nx;
        end
        if (cmd.out_load) begin
            out_reg <= {us_reg, bias_reg, filt_reg, used_reg, yaw_reg};
        end
    end

    assign sts.action   = act_reg;
    assign sts.mode     = cfg.mode;
    assign sts.learn_en = cfg.learn_en;
    assign sts.err_ok   = err_ok;
    assign m_tdata      = out_reg;

endmodule

// File: hw/rtl/gyi_ctrl.sv
// gyi_ctrl: sequencer of the gyro yaw integrator
// walks one word through bias, deadzone, biquad taps, divide and yaw update; a yaw load goes straight to the output
// depends on gyi_pkg
module gyi_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    output logic            m_tvalid,
    input  logic            m_tready,
    input  gyi_pkg::sts_t   sts,
    output gyi_pkg::cmd_t   cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_BIAS_UPD,
        S_USED,
        S_TAP,
        S_FILT,
        S_DT_MUL,
        S_DIV_INIT,
        S_DIV,
        S_ACCUM,
        S_OUT
    } state_t;

    localparam logic [gyi_pkg::TapW-1:0]    TapLast = gyi_pkg::TapW'(gyi_pkg::NumTaps);
    localparam logic [gyi_pkg::DivCntW-1:0] DivLast =
        gyi_pkg::DivCntW'(gyi_pkg::DivSteps - 1);

    state_t                      state_reg, state_next;
    logic [gyi_pkg::TapW-1:0]    tap_reg, tap_next;
    logic [gyi_pkg::DivCntW-1:0] cnt_reg, cnt_next;
    logic                        m_tvalid_reg, m_tvalid_next;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;

    always_comb begin
        state_next    = state_reg;
        tap_next      = tap_reg;
        cnt_next      = cnt_reg;
        m_tvalid_next = m_tvalid_reg & ~m_tready;

        cmd          = '0;
        cmd.mul_sel  = gyi_pkg::MUL_DT;
        cmd.acc_op   = gyi_pkg::ACC_HOLD;

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_START;
                end
            end
            S_START: begin
                if (sts.action) begin
                    cmd.load_yaw = 1'b1;
                    state_next   = S_OUT;
                end else if (sts.mode == gyi_pkg::MODE_BIAS) begin
                    cmd.mul_sel = gyi_pkg::MUL_BIAS;
                    state_next  = S_BIAS_UPD;
                end else begin
                    state_next = S_USED;
                end
            end
            S_BIAS_UPD: begin
                cmd.bias_upd = sts.learn_en & sts.err_ok;
                state_next   = S_USED;
            end
            S_USED: begin
                cmd.set_used = 1'b1;
                cmd.acc_op   = gyi_pkg::ACC_CLR;
                tap_next     = '0;
                if (sts.mode == gyi_pkg::MODE_LPF || sts.mode == gyi_pkg::MODE_BIAS) begin
                    state_next = S_TAP;
                end else begin
                    state_next = S_DT_MUL;
                end
            end
            S_TAP: begin
                // issue tap k, accumulate the registered product of tap k-1
                case (tap_reg)
                    3'd0:    cmd.mul_sel = gyi_pkg::MUL_B0;
                    3'd1:    cmd.mul_sel = gyi_pkg::MUL_B1;
                    3'd2:    cmd.mul_sel = gyi_pkg::MUL_B2;
                    3'd3:    cmd.mul_sel = gyi_pkg::MUL_A1;
                    default: cmd.mul_sel = gyi_pkg::MUL_A2;
                endcase
                if (tap_reg == 3'd0) begin
                    cmd.acc_op = gyi_pkg::ACC_HOLD;
                end else if (tap_reg <= 3'd3) begin
                    cmd.acc_op = gyi_pkg::ACC_ADD;
                end else begin
                    cmd.acc_op = gyi_pkg::ACC_SUB;
                end
                tap_next = tap_reg + 1'b1;
                if (tap_reg == TapLast) begin
                    state_next = S_FILT;
                end
            end
            S_FILT: begin
                cmd.filt_upd = 1'b1;
                state_next   = S_DT_MUL;
            end
            S_DT_MUL: begin
                cmd.mul_sel = gyi_pkg::MUL_DT;
                state_next  = S_DIV_INIT;
            end
            S_DIV_INIT: begin
                cmd.div_init = 1'b1;
                cnt_next     = '0;
                state_next   = S_DIV;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == DivLast) begin
                    state_next = S_ACCUM;
                end
            end
            S_ACCUM: begin
                cmd.yaw_upd = 1'b1;
                state_next  = S_OUT;
            end
            S_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    cmd.out_load  = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            tap_reg      <= '0;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            tap_reg      <= tap_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

// File: hw/rtl/gyro_yaw_integrator.sv
// gyro_yaw_integrator: one result word per input word, one word in the sequencer at a time
// a yaw load goes straight to the output; modes 0/1 skip the biquad, mode 2 runs it, mode 3 adds the bias step
// a new word is taken only once the last has left the sequencer; its run is set by the five biquad taps on the
//   shared 32x32 multiplier and the radix-8 divide by 10^6
// aresetn is synchronous: yaw, bias and filter history clear to zero, registers to defaults
// the output register frees the sequencer while a finished word waits on m_tready
module gyro_yaw_integrator (
    input  logic          aclk,
    input  logic          aresetn,

    // input word
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic          s_tuser,      // [0] action: 0 rate sample, 1 load yaw
    input  logic [95:0]   s_tdata,      // [31:0] rate_in, [47:32] interval_us, [95:48] angle_in

    // result word
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [159:0]  m_tdata,      // [47:0] yaw_angle, [79:48] rate_used,
                                        // [111:80] rate_filtered, [143:112] bias_estimate,
                                        // [159:144] interval_used

    // register port
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [4:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    gyi_pkg::cfg_t cfg;
    gyi_pkg::cmd_t cmd;
    gyi_pkg::sts_t sts;
    logic          clr_hist;

    // registers: mode, learn enable, deadzone, b0 b1 b2 a1 a2 at 4-byte steps
    gyi_regs u_regs (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .cfg      (cfg),
        .clr_hist (clr_hist)
    );

    // sequencer: handshakes and per-cycle commands
    gyi_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // datapath: multiplier, accumulator, divider, yaw and filter state
    gyi_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .cfg      (cfg),
        .clr_hist (clr_hist),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .sts      (sts),
        .m_tdata  (m_tdata)
    );

endmodule

// File: bench/tb_top.sv
// tb_top: self-checking bench for gyro_yaw_integrator, stream words in and out, register port writes
// predicts every result word from its own model of yaw, bias and biquad state
// depends on gyi_pkg and gyro_yaw_integrator
`timescale 1ns / 100ps

module tb_top;

    // saturation bounds and fixed-point constants of the datapath
    localparam longint Max32      = 64'sd2147483647;
    localparam longint Min32      = -64'sd2147483648;
    localparam longint Max48      = 64'sd140737488355327;
    localparam longint Min48      = -64'sd140737488355328;
    localparam longint LearnGain  = 64'sd33554;     // alpha 0.002 in Q0.24
    localparam longint LearnHalf  = 64'sd8388608;   // half lsb before the >> 24
    localparam longint LearnSpan  = 64'sd131072;    // 2 dps window on the bias error
    localparam longint DtLow      = 64'sd1000;
    localparam longint DtHigh     = 64'sd50000;
    localparam longint DtFallback = 64'sd10000;
    localparam longint UsPerSec   = 64'sd1000000;
    localparam int     CoefMax    = 32'sh7FFFFFFF;
    localparam int     CoefMin    = 32'sh80000000;
    localparam int     CoefUnity  = 32'sh40000000;  // 1.0 in Q2.30
    localparam int     HoldCycles = 200;
    localparam int     StallLimit = 4000;
    localparam int     DrainCycles = 40;
    localparam int     PhaseWords = 115;

    typedef enum int {
        REG_MODE,
        REG_LEARN_EN,
        REG_DEADZONE,
        REG_B0,
        REG_B1,
        REG_B2,
        REG_A1,
        REG_A2
    } reg_index_t;

    typedef struct {
        logic               action;
        logic signed [31:0] rate;
        logic [15:0]        interval;
        logic signed [47:0] angle;
    } gyro_word_t;

    typedef struct {
        logic signed [47:0] yaw;
        logic signed [31:0] used;
        logic signed [31:0] filt;
        logic signed [31:0] bias;
        logic [15:0]        interval;
    } yaw_word_t;

    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic         s_tuser  = 1'b0;
    logic [95:0]  s_tdata  = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [159:0] m_tdata;
    logic         psel     = 1'b0;
    logic         penable  = 1'b0;
    logic         pwrite   = 1'b0;
    logic [4:0]   paddr    = '0;
    logic [31:0]  pwdata   = '0;
    logic [31:0]  prdata;
    logic         pready;

    gyro_yaw_integrator DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),    // [0] action
        .s_tdata  (s_tdata),    // [31:0] rate_in, [47:32] interval_us, [95:48] angle_in
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),    // [47:0] yaw_angle, [79:48] rate_used, [111:80] rate_filtered,
                                // [143:112] bias_estimate, [159:144] interval_used
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // words waiting to go out, and result words still owed by the block
    gyro_word_t sample_queue[$];
    yaw_word_t  owed_results[$];

    int  fail_count  = 0;
    int  tx_idle_pct = 0;
    int  rx_idle_pct = 0;
    bit  word_taken  = 1'b0;   // set at the edge that accepts the word on s_tdata
    bit  hold_arm    = 1'b0;   // asks the receiver for one long stall
    int  hold_left   = 0;
    int  quiet_cycles = 0;

    // ------------------------------------------------------------------
    // shadow of the block: register settings and integrator state
    // ------------------------------------------------------------------
    gyi_pkg::mode_t cfg_mode = gyi_pkg::MODE_DZ;
    bit     cfg_learn = 1'b0;
    longint cfg_dz    = 3277;
    longint cfg_coef [5] = '{203409651, 406819302, 203409651, -363880367, 103798622};

    longint yaw_acc  = 0;
    longint bias_acc = 0;
    longint hist_x1 = 0, hist_x2 = 0, hist_y1 = 0, hist_y2 = 0;

    function automatic longint clamp(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // biquad with the exact sum of products, rounded half up by 2^30 and saturated;
    // the saturated output is what feeds back
    function automatic longint lowpass_step(longint x);
        logic signed [127:0] acc;
        longint              y;
        acc = cfg_coef[0] * x + cfg_coef[1] * hist_x1 + cfg_coef[2] * hist_x2
            - cfg_coef[3] * hist_y1 - cfg_coef[4] * hist_y2;
        acc = (acc + (128'sd1 <<< 29)) >>> 30;
        if (acc > 128'(Max32))
            y = Max32;
        else if (acc < 128'(Min32))
            y = Min32;
        else
            y = longint'(acc);
        hist_x2 = hist_x1;
        hist_x1 = x;
        hist_y2 = hist_y1;
        hist_y1 = y;
        return y;
    endfunction

    // one accepted word in, the result word it must produce out
    function automatic yaw_word_t integrate_word(gyro_word_t w);
        yaw_word_t r;
        longint    rate, us, used, filt, err, prod, mag, delta;
        rate = w.rate;
        us   = w.interval;
        used = 0;
        filt = 0;
        if (us < DtLow || us > DtHigh)
            us = DtFallback;
        if (w.action) begin
            // yaw load: history cleared, bias kept
            yaw_acc = w.angle;
            hist_x1 = 0;
            hist_x2 = 0;
            hist_y1 = 0;
            hist_y2 = 0;
        end else begin
            if (cfg_mode == gyi_pkg::MODE_BIAS) begin
                if (cfg_learn) begin
                    err = rate - bias_acc;
                    if (err >= -LearnSpan && err <= LearnSpan)
                        bias_acc = clamp(bias_acc + ((err * LearnGain + LearnHalf) >>> 24),
                                         Min32, Max32);
                end
                used = clamp(rate - bias_acc, Min32, Max32);
            end else begin
                used = rate;
            end
            if (cfg_mode != gyi_pkg::MODE_RAW && ((used < 0) ? -used : used) < cfg_dz)
                used = 0;
            if (cfg_mode == gyi_pkg::MODE_LPF || cfg_mode == gyi_pkg::MODE_BIAS)
                filt = lowpass_step(used);
            else
                filt = used;
            // rate times interval over 10^6, ties away from zero
            prod  = filt * us;
            mag   = (prod < 0) ? -prod : prod;
            delta = (mag + UsPerSec / 2) / UsPerSec;
            if (prod < 0)
                delta = -delta;
            yaw_acc = clamp(yaw_acc + delta, Min48, Max48);
        end
        r.yaw      = yaw_acc[47:0];
        r.used     = used[31:0];
        r.filt     = filt[31:0];
        r.bias     = bias_acc[31:0];
        r.interval = us[15:0];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // random word shaped to hit the bias window, the deadzone edge and range checks
    // ------------------------------------------------------------------
    function automatic gyro_word_t random_word();
        gyro_word_t w;
        int         pick;
        longint     edge_mag;
        w.action = ($urandom_range(99) < 6);
        pick = $urandom_range(9);
        if (pick == 0)
            w.angle = 48'(Max48 - longint'($urandom_range(1 << 20)));
        else if (pick == 1)
            w.angle = 48'(Min48 + longint'($urandom_range(1 << 20)));
        else
            w.angle = 48'({$urandom, $urandom});
        pick = $urandom_range(99);
        if (pick < 40) begin
            // small rates near the learning window, some just outside it
            w.rate = int'($urandom_range(300000)) - 150000;
        end else if (pick < 60) begin
            edge_mag = cfg_dz + longint'($urandom_range(4)) - 2;
            w.rate = 32'($urandom_range(1) ? edge_mag : -edge_mag);
        end else if (pick < 85) begin
            w.rate = int'($urandom_range(1 << 25)) - (1 << 24);
        end else begin
            w.rate = $urandom;
        end
        pick = $urandom_range(99);
        if (pick < 70) begin
            w.interval = 16'($urandom_range(50000, 1000));
        end else if (pick < 80) begin
            case ($urandom_range(5))
                0: w.interval = 16'd999;
                1: w.interval = 16'd1000;
                2: w.interval = 16'd50000;
                3: w.interval = 16'd50001;
                4: w.interval = 16'd0;
                default: w.interval = 16'hFFFF;
            endcase
        end else begin
            w.interval = 16'($urandom_range(65535));
        end
        return w;
    endfunction

    // ------------------------------------------------------------------
    // register port: setup then access, shadow updated once the write lands
    // ------------------------------------------------------------------
    task automatic write_reg(reg_index_t idx, logic [31:0] val);
        @(negedge aclk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= 5'(int'(idx) * 4);
        pwdata  <= val;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_MODE: begin
                // a mode write restarts bias and filter, yaw is kept
                cfg_mode = gyi_pkg::mode_t'(val[1:0]);
                bias_acc = 0;
                hist_x1  = 0;
                hist_x2  = 0;
                hist_y1  = 0;
                hist_y2  = 0;
            end
            REG_LEARN_EN: cfg_learn = val[0];
            REG_DEADZONE: cfg_dz = val[15:0];
            default: cfg_coef[int'(idx) - int'(REG_B0)] = $signed(val);
        endcase
    endtask

    task automatic apply_setup(gyi_pkg::mode_t m, bit learn, int dz, int b0, int b1, int b2,
                               int a1, int a2);
        write_reg(REG_MODE, 32'(m));
        write_reg(REG_LEARN_EN, 32'(learn));
        write_reg(REG_DEADZONE, dz);
        write_reg(REG_B0, b0);
        write_reg(REG_B1, b1);
        write_reg(REG_B2, b2);
        write_reg(REG_A1, a1);
        write_reg(REG_A2, a2);
    endtask

    task automatic push_sample(longint rate, int us);
        gyro_word_t w;
        w.action   = 1'b0;
        w.rate     = rate[31:0];
        w.interval = us[15:0];
        w.angle    = '0;
        sample_queue.push_back(w);
    endtask

    task automatic push_load(longint angle, int us);
        gyro_word_t w;
        w.action   = 1'b1;
        w.rate     = $urandom;
        w.interval = us[15:0];
        w.angle    = angle[47:0];
        sample_queue.push_back(w);
    endtask

    // waits until the sender is idle and every owed result is back
    task automatic wait_drained();
        while (sample_queue.size() != 0 || s_tvalid || owed_results.size() != 0)
            @(posedge aclk);
    endtask

    task automatic check_field(string name, longint want, longint got);
        if (want != got) begin
            $error("%s expected %0d actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    // ------------------------------------------------------------------
    // driver: presents the next queued word at the falling edge, holds it until taken
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        gyro_word_t w;
        if (!s_tvalid || word_taken) begin
            word_taken = 1'b0;
            if (aresetn && sample_queue.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                w = sample_queue.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= w.action;
                s_tdata  <= {w.angle, w.interval, w.rate};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: random back-pressure, plus one long stall on request
    always @(negedge aclk) begin
        if (hold_arm) begin
            hold_arm  = 1'b0;
            hold_left = HoldCycles;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // monitor: checks result words first, then predicts for the word accepted
    // at this edge, so one edge never races itself
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        gyro_word_t in_w;
        yaw_word_t  want;
        if (aresetn && m_tvalid && m_tready) begin
            if (owed_results.size() == 0) begin
                $error("result word with nothing expected");
                fail_count++;
            end else begin
                want = owed_results.pop_front();
                check_field("yaw_angle", want.yaw, $signed(m_tdata[47:0]));
                check_field("rate_used", want.used, $signed(m_tdata[79:48]));
                check_field("rate_filtered", want.filt, $signed(m_tdata[111:80]));
                check_field("bias_estimate", want.bias, $signed(m_tdata[143:112]));
                check_field("interval_used", want.interval, m_tdata[159:144]);
            end
        end
        if (aresetn && s_tvalid && s_tready) begin
            in_w.action   = s_tuser;
            in_w.rate     = s_tdata[31:0];
            in_w.interval = s_tdata[47:32];
            in_w.angle    = s_tdata[95:48];
            owed_results.push_back(integrate_word(in_w));
            word_taken = 1'b1;
        end
    end

    // watchdog: too long without any word or register write going through
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= StallLimit) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus: directed corners, then random phases over several settings
    // ------------------------------------------------------------------
    initial begin : stimulus
        int p;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        tx_idle_pct = 16;
        rx_idle_pct = 69;
        @(posedge aclk);

        // reset settings: deadzone mode, 0.05 dps deadzone
        push_load(0, 0);                    // load with an out-of-range interval
        push_sample(3277, 1000);            // magnitude equal to the deadzone passes
        push_sample(-3276, 50000);          // just inside the deadzone, zeroed
        push_sample(-3277, 999);            // interval below range
        push_sample(Max32, 50001);          // interval above range
        push_sample(Min32, 65535);
        push_load(Max48, 50000);
        push_sample(Max32, 50000);          // yaw pinned at the top
        push_load(Min48, 1);
        push_sample(Min32, 50000);          // yaw pinned at the bottom
        push_load(-1, 40000);
        wait_drained();

        // raw mode: half-lsb ties on the integration round away from zero
        apply_setup(gyi_pkg::MODE_RAW, 1'b0, 3277, 203409651, 406819302, 203409651,
                    -363880367, 103798622);
        @(posedge aclk);
        push_sample(10, 50000);
        push_sample(-10, 50000);
        push_sample(0, 1000);
        wait_drained();

        // low-pass from full scale, then a load clearing the history
        apply_setup(gyi_pkg::MODE_LPF, 1'b0, 0, 203409651, 406819302, 203409651,
                    -363880367, 103798622);
        @(posedge aclk);
        push_sample(Max32, 10000);
        push_sample(Max32, 10000);
        push_load(12345, 20000);
        push_sample(-100000, 10000);
        wait_drained();

        // bias learning at both edges of the window, then bias subtraction saturating
        apply_setup(gyi_pkg::MODE_BIAS, 1'b1, 0, 203409651, 406819302, 203409651,
                    -363880367, 103798622);
        @(posedge aclk);
        push_sample(131072, 10000);         // error right at the upper edge, learns
        push_sample(262 - 131073, 10000);   // one past the lower edge, no learning
        push_sample(131072, 10000);
        push_sample(524 - 131072, 10000);   // error right at the lower edge
        push_sample(Min32, 10000);          // rate minus positive bias clips low
        push_load(0, 10000);

        for (p = 0; p < 9; p++) begin
            wait_drained();
            if (p == 3) begin
                tx_idle_pct = 69;
                rx_idle_pct = 16;
            end else if (p == 6) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            case (p)
                0: apply_setup(gyi_pkg::MODE_BIAS, 1'b1, 0, 203409651, 406819302, 203409651,
                               -363880367, 103798622);
                // extreme taps drive the filter into saturation
                1: apply_setup(gyi_pkg::MODE_LPF, 1'b0, 65535, CoefMax, CoefMin, CoefMax,
                               CoefMin, CoefMax);
                2: apply_setup(gyi_pkg::MODE_RAW, 1'b1, $urandom_range(65535), 203409651,
                               406819302, 203409651, -363880367, 103798622);
                3: apply_setup(gyi_pkg::MODE_DZ, 1'b0, $urandom_range(65535), $urandom,
                               $urandom, $urandom, $urandom, $urandom);
                4: apply_setup(gyi_pkg::MODE_BIAS, 1'b1, 3277, 203409651, 406819302, 203409651,
                               -363880367, 103798622);
                5: apply_setup(gyi_pkg::MODE_LPF, 1'b1, $urandom_range(8000), $urandom,
                               $urandom, $urandom, $urandom, $urandom);
                // filter reduced to a pass-through
                6: apply_setup(gyi_pkg::MODE_BIAS, 1'b0, 3277, CoefUnity, 0, 0, 0, 0);
                7: apply_setup(gyi_pkg::MODE_BIAS, 1'b1, 0, 203409651, 406819302, 203409651,
                               -363880367, 103798622);
                default: apply_setup(gyi_pkg::MODE_DZ, 1'b0, 3277, CoefMin, CoefMax, CoefMin,
                                     CoefMax, CoefMin);
            endcase
            @(posedge aclk);
            repeat (PhaseWords) sample_queue.push_back(random_word());
            // long receiver stall while the sender keeps offering, input must back up
            if (p == 7)
                hold_arm = 1'b1;
        end

        wait_drained();
        repeat (DrainCycles) @(posedge aclk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
